// File: design/tcaf_pkg.sv
// ----------------------------------------------------------------------------
// tcaf_pkg
// Shared types, constants and microcode for the touch calibration affine fit.
// ----------------------------------------------------------------------------
package tcaf_pkg;

  localparam int unsigned DefPointCount = 5;
  localparam int unsigned RawW     = 12;
  localparam int unsigned ScrW     = 10;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned CofW     = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned AccW     = 128;
  localparam int unsigned FracBits = 16;
  localparam int unsigned DivSteps = 128;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned QuoW     = CoefW + 2;
  localparam int unsigned PcW      = 6;
  localparam int unsigned UcodeLen = 48;
  localparam int unsigned CofCnt   = 6;
  localparam int unsigned IdxW     = 3;

  // Cofactor register slots and the determinant slot.
  localparam logic [IdxW-1:0] CofA   = 3'd0;
  localparam logic [IdxW-1:0] CofB   = 3'd1;
  localparam logic [IdxW-1:0] CofC   = 3'd2;
  localparam logic [IdxW-1:0] CofE   = 3'd3;
  localparam logic [IdxW-1:0] CofF   = 3'd4;
  localparam logic [IdxW-1:0] CofI   = 3'd5;
  localparam logic [IdxW-1:0] DetIdx = 3'd6;

  // Coefficient slots in output order.
  localparam logic [IdxW-1:0] CoXOff = 3'd0;
  localparam logic [IdxW-1:0] CoXRx  = 3'd1;
  localparam logic [IdxW-1:0] CoXRy  = 3'd2;
  localparam logic [IdxW-1:0] CoYOff = 3'd3;
  localparam logic [IdxW-1:0] CoYRx  = 3'd4;
  localparam logic [IdxW-1:0] CoYRy  = 3'd5;
  localparam logic [IdxW-1:0] NoIdx  = 3'd7;

  typedef enum logic [2:0] {
    UK_MAC, UK_STORE, UK_CHECK, UK_DIV, UK_END
  } uop_kind_e;

  typedef enum logic [3:0] {
    SA_X, SA_Y, SA_X2, SA_Y2, SA_XY,
    SA_CA, SA_CB, SA_CC, SA_CE, SA_CF, SA_CI
  } sel_a_e;

  typedef enum logic [3:0] {
    SB_N, SB_X, SB_Y, SB_X2, SB_Y2, SB_XY,
    SB_SX, SB_SXRX, SB_SXRY, SB_SY, SB_SYRX, SB_SYRY
  } sel_b_e;

  typedef struct packed {
    uop_kind_e       kind;
    logic            clr;
    logic            sub;
    sel_a_e          asel;
    sel_b_e          bsel;
    logic [IdxW-1:0] idx;
  } uop_t;

  typedef struct packed {
    logic            acc_pt;
    logic            clr_sums;
    logic            mul_en;
    logic            mul_hi;
    logic            mac_clr;
    logic            mac_sub;
    sel_a_e          asel;
    sel_b_e          bsel;
    logic            store_en;
    logic            div_load;
    logic            div_step;
    logic            div_wr;
    logic [IdxW-1:0] idx;
    logic            out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
  } dp_sts_t;

  function automatic uop_t mk(uop_kind_e k, logic c, logic s, sel_a_e a, sel_b_e b,
                              logic [IdxW-1:0] i);
    uop_t u;
    u.kind = k;
    u.clr  = c;
    u.sub  = s;
    u.asel = a;
    u.bsel = b;
    u.idx  = i;
    return u;
  endfunction

  function automatic uop_t mac(logic c, logic s, sel_a_e a, sel_b_e b);
    return mk(UK_MAC, c, s, a, b, NoIdx);
  endfunction

  function automatic uop_t ctl(uop_kind_e k, logic [IdxW-1:0] i);
    return mk(k, 1'b0, 1'b0, SA_X, SB_N, i);
  endfunction

  function automatic uop_t ucode(logic [PcW-1:0] pc);
    uop_t u;
    u = ctl(UK_END, NoIdx);
    case (pc)
      6'd0:  u = mac(1'b1, 1'b0, SA_X2, SB_Y2);
      6'd1:  u = mac(1'b0, 1'b1, SA_XY, SB_XY);
      6'd2:  u = ctl(UK_STORE, CofA);
      6'd3:  u = mac(1'b1, 1'b0, SA_XY, SB_Y);
      6'd4:  u = mac(1'b0, 1'b1, SA_X, SB_Y2);
      6'd5:  u = ctl(UK_STORE, CofB);
      6'd6:  u = mac(1'b1, 1'b0, SA_X, SB_XY);
      6'd7:  u = mac(1'b0, 1'b1, SA_Y, SB_X2);
      6'd8:  u = ctl(UK_STORE, CofC);
      6'd9:  u = mac(1'b1, 1'b0, SA_Y2, SB_N);
      6'd10: u = mac(1'b0, 1'b1, SA_Y, SB_Y);
      6'd11: u = ctl(UK_STORE, CofE);
      6'd12: u = mac(1'b1, 1'b0, SA_X, SB_Y);
      6'd13: u = mac(1'b0, 1'b1, SA_XY, SB_N);
      6'd14: u = ctl(UK_STORE, CofF);
      6'd15: u = mac(1'b1, 1'b0, SA_X2, SB_N);
      6'd16: u = mac(1'b0, 1'b1, SA_X, SB_X);
      6'd17: u = ctl(UK_STORE, CofI);
      6'd18: u = mac(1'b1, 1'b0, SA_CA, SB_N);
      6'd19: u = mac(1'b0, 1'b0, SA_CB, SB_X);
      6'd20: u = mac(1'b0, 1'b0, SA_CC, SB_Y);
      6'd21: u = ctl(UK_STORE, DetIdx);
      6'd22: u = ctl(UK_CHECK, NoIdx);
      6'd23: u = mac(1'b1, 1'b0, SA_CA, SB_SX);
      6'd24: u = mac(1'b0, 1'b0, SA_CB, SB_SXRX);
      6'd25: u = mac(1'b0, 1'b0, SA_CC, SB_SXRY);
      6'd26: u = ctl(UK_DIV, CoXOff);
      6'd27: u = mac(1'b1, 1'b0, SA_CB, SB_SX);
      6'd28: u = mac(1'b0, 1'b0, SA_CE, SB_SXRX);
      6'd29: u = mac(1'b0, 1'b0, SA_CF, SB_SXRY);
      6'd30: u = ctl(UK_DIV, CoXRx);
      6'd31: u = mac(1'b1, 1'b0, SA_CC, SB_SX);
      6'd32: u = mac(1'b0, 1'b0, SA_CF, SB_SXRX);
      6'd33: u = mac(1'b0, 1'b0, SA_CI, SB_SXRY);
      6'd34: u = ctl(UK_DIV, CoXRy);
      6'd35: u = mac(1'b1, 1'b0, SA_CA, SB_SY);
      6'd36: u = mac(1'b0, 1'b0, SA_CB, SB_SYRX);
      6'd37: u = mac(1'b0, 1'b0, SA_CC, SB_SYRY);
      6'd38: u = ctl(UK_DIV, CoYOff);
      6'd39: u = mac(1'b1, 1'b0, SA_CB, SB_SY);
      6'd40: u = mac(1'b0, 1'b0, SA_CE, SB_SYRX);
      6'd41: u = mac(1'b0, 1'b0, SA_CF, SB_SYRY);
      6'd42: u = ctl(UK_DIV, CoYRx);
      6'd43: u = mac(1'b1, 1'b0, SA_CC, SB_SY);
      6'd44: u = mac(1'b0, 1'b0, SA_CF, SB_SYRX);
      6'd45: u = mac(1'b0, 1'b0, SA_CI, SB_SYRY);
      6'd46: u = ctl(UK_DIV, CoYRy);
      default: u = ctl(UK_END, NoIdx);
    endcase
    return u;
  endfunction

endpackage

// File: design/tcaf_datapath.sv
// ----------------------------------------------------------------------------
// tcaf_datapath
// Point sums, shared multiply-accumulate unit, cofactor registers, serial
// divider and output registers.
// ----------------------------------------------------------------------------
module tcaf_datapath #(
  parameter int unsigned POINT_COUNT = tcaf_pkg::DefPointCount
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcaf_pkg::dp_cmd_t                   cmd_i,
  output tcaf_pkg::dp_sts_t                   sts_o,
  input  logic [tcaf_pkg::RawW-1:0]           raw_x_i,
  input  logic [tcaf_pkg::RawW-1:0]           raw_y_i,
  input  logic [tcaf_pkg::ScrW-1:0]           screen_x_i,
  input  logic [tcaf_pkg::ScrW-1:0]           screen_y_i,
  output logic                                status_o,
  output logic signed [tcaf_pkg::CoefW-1:0]   x_offset_o,
  output logic signed [tcaf_pkg::CoefW-1:0]   x_from_raw_x_o,
  output logic signed [tcaf_pkg::CoefW-1:0]   x_from_raw_y_o,
  output logic signed [tcaf_pkg::CoefW-1:0]   y_offset_o,
  output logic signed [tcaf_pkg::CoefW-1:0]   y_from_raw_x_o,
  output logic signed [tcaf_pkg::CoefW-1:0]   y_from_raw_y_o
);
  import tcaf_pkg::*;

  localparam longint unsigned RawMax = (64'd1 << RawW) - 64'd1;
  localparam longint unsigned ScrMax = (64'd1 << ScrW) - 64'd1;
  localparam int unsigned SumRW  = $clog2(POINT_COUNT * RawMax + 1);
  localparam int unsigned SumRRW = $clog2(POINT_COUNT * RawMax * RawMax + 1);
  localparam int unsigned SumSW  = $clog2(POINT_COUNT * ScrMax + 1);
  localparam int unsigned SumSRW = $clog2(POINT_COUNT * ScrMax * RawMax + 1);
  localparam int unsigned BW     = SumRRW;
  localparam int unsigned PW     = HalfW + 1 + BW + 1;

  logic [SumRW-1:0]  s_x_q, s_y_q;
  logic [SumRRW-1:0] s_x2_q, s_y2_q, s_xy_q;
  logic [SumSW-1:0]  s_sx_q, s_sy_q;
  logic [SumSRW-1:0] s_sxrx_q, s_sxry_q, s_syrx_q, s_syry_q;

  logic [2*RawW-1:0]    p_xx, p_yy, p_xy;
  logic [RawW+ScrW-1:0] p_sxrx, p_sxry, p_syrx, p_syry;

  logic signed [CofW-1:0]  cof_q [CofCnt];
  logic signed [CofW-1:0]  det_q;
  logic [CofW-1:0]         det_mag_q;
  logic                    det_zero_q;
  logic signed [CofW-1:0]  opa;
  logic [BW-1:0]           opb;
  logic signed [HalfW:0]   mul_a;
  logic signed [BW:0]      mul_b;
  logic signed [PW-1:0]    prod_q;
  logic                    prod_vld_q, prod_hi_q, prod_clr_q, prod_sub_q;
  logic signed [AccW-1:0]  term_ext, term_sh, addend, acc_q;

  logic [AccW-1:0]         acc_mag;
  logic [AccW-1:0]         dvd_q;
  logic [CofW-1:0]         rem_q;
  logic [CofW:0]           rem_sh;
  logic                    rem_ge;
  logic [QuoW-1:0]         quo_q;
  logic                    ovf_q, neg_q;
  logic signed [CoefW-1:0] sat;
  logic signed [CoefW-1:0] coef_q [CofCnt];

  assign p_xx   = raw_x_i * raw_x_i;
  assign p_yy   = raw_y_i * raw_y_i;
  assign p_xy   = raw_x_i * raw_y_i;
  assign p_sxrx = screen_x_i * raw_x_i;
  assign p_sxry = screen_x_i * raw_y_i;
  assign p_syrx = screen_y_i * raw_x_i;
  assign p_syry = screen_y_i * raw_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_x_q    <= '0;
      s_y_q    <= '0;
      s_x2_q   <= '0;
      s_y2_q   <= '0;
      s_xy_q   <= '0;
      s_sx_q   <= '0;
      s_sy_q   <= '0;
      s_sxrx_q <= '0;
      s_sxry_q <= '0;
      s_syrx_q <= '0;
      s_syry_q <= '0;
    end else if (cmd_i.clr_sums) begin
      s_x_q    <= '0;
      s_y_q    <= '0;
      s_x2_q   <= '0;
      s_y2_q   <= '0;
      s_xy_q   <= '0;
      s_sx_q   <= '0;
      s_sy_q   <= '0;
      s_sxrx_q <= '0;
      s_sxry_q <= '0;
      s_syrx_q <= '0;
      s_syry_q <= '0;
    end else if (cmd_i.acc_pt) begin
      s_x_q    <= s_x_q + SumRW'(raw_x_i);
      s_y_q    <= s_y_q + SumRW'(raw_y_i);
      s_x2_q   <= s_x2_q + SumRRW'(p_xx);
      s_y2_q   <= s_y2_q + SumRRW'(p_yy);
      s_xy_q   <= s_xy_q + SumRRW'(p_xy);
      s_sx_q   <= s_sx_q + SumSW'(screen_x_i);
      s_sy_q   <= s_sy_q + SumSW'(screen_y_i);
      s_sxrx_q <= s_sxrx_q + SumSRW'(p_sxrx);
      s_sxry_q <= s_sxry_q + SumSRW'(p_sxry);
      s_syrx_q <= s_syrx_q + SumSRW'(p_syrx);
      s_syry_q <= s_syry_q + SumSRW'(p_syry);
    end
  end

  always_comb begin
    case (cmd_i.asel)
      SA_X:    opa = CofW'(s_x_q);
      SA_Y:    opa = CofW'(s_y_q);
      SA_X2:   opa = CofW'(s_x2_q);
      SA_Y2:   opa = CofW'(s_y2_q);
      SA_XY:   opa = CofW'(s_xy_q);
      SA_CA:   opa = cof_q[CofA];
      SA_CB:   opa = cof_q[CofB];
      SA_CC:   opa = cof_q[CofC];
      SA_CE:   opa = cof_q[CofE];
      SA_CF:   opa = cof_q[CofF];
      SA_CI:   opa = cof_q[CofI];
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.bsel)
      SB_N:    opb = BW'(POINT_COUNT);
      SB_X:    opb = BW'(s_x_q);
      SB_Y:    opb = BW'(s_y_q);
      SB_X2:   opb = BW'(s_x2_q);
      SB_Y2:   opb = BW'(s_y2_q);
      SB_XY:   opb = BW'(s_xy_q);
      SB_SX:   opb = BW'(s_sx_q);
      SB_SXRX: opb = BW'(s_sxrx_q);
      SB_SXRY: opb = BW'(s_sxry_q);
      SB_SY:   opb = BW'(s_sy_q);
      SB_SYRX: opb = BW'(s_syrx_q);
      SB_SYRY: opb = BW'(s_syry_q);
      default: opb = '0;
    endcase
  end

  // The low half of the signed operand is unsigned, the high half signed.
  assign mul_a = cmd_i.mul_hi ? {opa[CofW-1], opa[CofW-1:HalfW]} : {1'b0, opa[HalfW-1:0]};
  assign mul_b = {1'b0, opb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q     <= PW'(mul_a * mul_b);
      prod_hi_q  <= cmd_i.mul_hi;
      prod_clr_q <= cmd_i.mac_clr && !cmd_i.mul_hi;
      prod_sub_q <= cmd_i.mac_sub;
    end
  end

  assign term_ext = {{(AccW-PW){prod_q[PW-1]}}, prod_q};
  assign term_sh  = prod_hi_q ? (term_ext <<< HalfW) : term_ext;
  assign addend   = prod_sub_q ? -term_sh : term_sh;
  assign acc_mag  = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign rem_sh   = {rem_q, dvd_q[AccW-1]};
  assign rem_ge   = rem_sh >= {1'b0, det_mag_q};

  always_ff @(posedge clk_i) begin
    if (prod_vld_q) begin
      acc_q <= prod_clr_q ? addend : acc_q + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_zero_q <= 1'b0;
    end else if (cmd_i.store_en && cmd_i.idx == DetIdx) begin
      det_zero_q <= acc_q[CofW-1:0] == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en) begin
      if (cmd_i.idx == DetIdx) begin
        det_q     <= acc_q[CofW-1:0];
        det_mag_q <= acc_q[CofW-1] ? CofW'(-acc_q[CofW-1:0]) : acc_q[CofW-1:0];
      end else if (cmd_i.idx < DetIdx) begin
        cof_q[cmd_i.idx] <= acc_q[CofW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dvd_q <= acc_mag << FracBits;
      neg_q <= acc_q[AccW-1] ^ det_q[CofW-1];
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_ge ? CofW'(rem_sh - {1'b0, det_mag_q}) : rem_sh[CofW-1:0];
      quo_q <= {quo_q[QuoW-2:0], rem_ge};
      ovf_q <= ovf_q | quo_q[QuoW-1];
    end
  end

  always_comb begin
    if (neg_q) begin
      if (ovf_q || quo_q > QuoW'(34'h0_8000_0000)) begin
        sat = {1'b1, {(CoefW-1){1'b0}}};
      end else begin
        sat = CoefW'(-quo_q[CoefW-1:0]);
      end
    end else begin
      if (ovf_q || quo_q > QuoW'(34'h0_7FFF_FFFF)) begin
        sat = {1'b0, {(CoefW-1){1'b1}}};
      end else begin
        sat = quo_q[CoefW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_wr && cmd_i.idx < DetIdx) begin
      coef_q[cmd_i.idx] <= sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o       <= det_zero_q;
      x_offset_o     <= det_zero_q ? '0 : coef_q[CoXOff];
      x_from_raw_x_o <= det_zero_q ? '0 : coef_q[CoXRx];
      x_from_raw_y_o <= det_zero_q ? '0 : coef_q[CoXRy];
      y_offset_o     <= det_zero_q ? '0 : coef_q[CoYOff];
      y_from_raw_x_o <= det_zero_q ? '0 : coef_q[CoYRx];
      y_from_raw_y_o <= det_zero_q ? '0 : coef_q[CoYRy];
    end
  end

  assign sts_o.det_zero = det_zero_q;

endmodule

// File: design/tcaf_ctrl.sv
// ----------------------------------------------------------------------------
// tcaf_ctrl
// Point counter, microcode sequencer and handshake control.
// ----------------------------------------------------------------------------
module tcaf_ctrl #(
  parameter int unsigned POINT_COUNT = tcaf_pkg::DefPointCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcaf_pkg::dp_cmd_t cmd_o,
  input  tcaf_pkg::dp_sts_t sts_i
);
  import tcaf_pkg::*;

  localparam int unsigned CntW = $clog2(POINT_COUNT);
  localparam logic [CntW-1:0] LastPt = CntW'(POINT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_MAC_LO, S_MAC_HI, S_DRAIN, S_DIV, S_DIV_WR, S_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [PcW-1:0]       pc_q, pc_d;
  logic [DivCntW-1:0]   dcnt_q, dcnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 in_acc, out_free;
  uop_t                 uop;

  assign uop        = ucode(pc_q);
  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pc_d        = pc_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o          = '0;
    cmd_o.asel     = uop.asel;
    cmd_o.bsel     = uop.bsel;
    cmd_o.mac_clr  = uop.clr;
    cmd_o.mac_sub  = uop.sub;
    cmd_o.idx      = uop.idx;
    cmd_o.acc_pt   = in_acc;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q == LastPt) begin
            cnt_d   = '0;
            pc_d    = '0;
            state_d = S_RUN;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_RUN: begin
        case (uop.kind)
          UK_MAC: state_d = S_MAC_LO;
          UK_STORE: begin
            cmd_o.store_en = 1'b1;
            pc_d           = pc_q + 1'b1;
          end
          UK_CHECK: begin
            if (sts_i.det_zero) begin
              state_d = S_FINISH;
            end else begin
              pc_d = pc_q + 1'b1;
            end
          end
          UK_DIV: begin
            cmd_o.div_load = 1'b1;
            dcnt_d         = '0;
            state_d        = S_DIV;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_MAC_LO: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MAC_HI;
      end
      S_MAC_HI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = 1'b1;
        state_d      = S_DRAIN;
      end
      S_DRAIN: begin
        pc_d    = pc_q + 1'b1;
        state_d = S_RUN;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 1'b1;
        if (dcnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = S_DIV_WR;
        end
      end
      S_DIV_WR: begin
        cmd_o.div_wr = 1'b1;
        pc_d         = pc_q + 1'b1;
        state_d      = S_RUN;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clr_sums = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pc_q        <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pc_q        <= pc_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result beat raised outside the finish step");

  a_pc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> pc_q < PcW'(UcodeLen))
    else $error("microcode counter ran past the program");

  a_last_point_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cnt_q == LastPt) |=> state_q == S_RUN && pc_q == '0)
    else $error("last point did not start the fit");
`endif

endmodule

// File: design/touch_calibration_affine_fit_core.sv
// ----------------------------------------------------------------------------
// touch_calibration_affine_fit_core
// Least-squares affine touchscreen calibration over a set of points.
// ----------------------------------------------------------------------------
// Each point but the last only adds to the point sums. The last point
// starts the fit (the divisions are skipped when the fit is singular):
// 33 two-half multiply-accumulates on one shared multiplier
// and six 128-step restoring divisions on one serial divider.
// Reset clears the point sums and the point count; no result is pending.
module touch_calibration_affine_fit_core #(
  parameter int unsigned POINT_COUNT = tcaf_pkg::DefPointCount
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tcaf_pkg::RawW-1:0]         raw_x_i,
  input  logic [tcaf_pkg::RawW-1:0]         raw_y_i,
  input  logic [tcaf_pkg::ScrW-1:0]         screen_x_i,
  input  logic [tcaf_pkg::ScrW-1:0]         screen_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              status_o,
  output logic signed [tcaf_pkg::CoefW-1:0] x_offset_o,
  output logic signed [tcaf_pkg::CoefW-1:0] x_from_raw_x_o,
  output logic signed [tcaf_pkg::CoefW-1:0] x_from_raw_y_o,
  output logic signed [tcaf_pkg::CoefW-1:0] y_offset_o,
  output logic signed [tcaf_pkg::CoefW-1:0] y_from_raw_x_o,
  output logic signed [tcaf_pkg::CoefW-1:0] y_from_raw_y_o
);
  import tcaf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcaf_ctrl #(
    .POINT_COUNT(POINT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tcaf_datapath #(
    .POINT_COUNT(POINT_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .raw_x_i       (raw_x_i),
    .raw_y_i       (raw_y_i),
    .screen_x_i    (screen_x_i),
    .screen_y_i    (screen_y_i),
    .status_o      (status_o),
    .x_offset_o    (x_offset_o),
    .x_from_raw_x_o(x_from_raw_x_o),
    .x_from_raw_y_o(x_from_raw_y_o),
    .y_offset_o    (y_offset_o),
    .y_from_raw_x_o(y_from_raw_x_o),
    .y_from_raw_y_o(y_from_raw_y_o)
  );

endmodule

// File: bench/tb_touch_calibration_affine_fit_core.sv
// ----------------------------------------------------------------------------
// tb_touch_calibration_affine_fit_core
// Sends sets of calibration points to the affine fit core and checks every
// fit beat against an exact integer least-squares predictor, with random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_touch_calibration_affine_fit_core;
  import tcaf_pkg::*;

  localparam int unsigned NPts = DefPointCount;
  localparam int unsigned RandSets = 186;
  localparam int unsigned LongHold = 3000;

  typedef struct packed {
    logic [RawW-1:0] rx;
    logic [RawW-1:0] ry;
    logic [ScrW-1:0] sx;
    logic [ScrW-1:0] sy;
    logic            singular;
  } point_t;

  typedef struct {
    logic                    status;
    logic signed [CoefW-1:0] co[CofCnt];
  } fit_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [RawW-1:0]         raw_x_i;
  logic [RawW-1:0]         raw_y_i;
  logic [ScrW-1:0]         screen_x_i;
  logic [ScrW-1:0]         screen_y_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    status_o;
  logic signed [CoefW-1:0] x_offset_o;
  logic signed [CoefW-1:0] x_from_raw_x_o;
  logic signed [CoefW-1:0] x_from_raw_y_o;
  logic signed [CoefW-1:0] y_offset_o;
  logic signed [CoefW-1:0] y_from_raw_x_o;
  logic signed [CoefW-1:0] y_from_raw_y_o;

  touch_calibration_affine_fit_core u_top (.*);

  fit_t        fits_pending[$];
  int          errors;
  int          fits_seen;
  bit          sending_done;
  longint      pts_in_set;
  longint      s_rx, s_ry, s_rx2, s_ry2, s_rxry;
  longint      s_sx, s_sxrx, s_sxry, s_sy, s_syrx, s_syry;

  // Directed sets: all zero, one coincident corner point, the full raw
  // range, a tiny raw spread at the top corner that drives the fit out of
  // range, and collinear raw points.
  point_t directed_pts[25] = '{
    '{12'd0, 12'd0, 10'd0, 10'd0, 1'b1}, '{12'd0, 12'd0, 10'd0, 10'd0, 1'b1},
    '{12'd0, 12'd0, 10'd0, 10'd0, 1'b1}, '{12'd0, 12'd0, 10'd0, 10'd0, 1'b1},
    '{12'd0, 12'd0, 10'd0, 10'd0, 1'b1},
    '{12'd4095, 12'd4095, 10'd1023, 10'd1023, 1'b1},
    '{12'd4095, 12'd4095, 10'd1023, 10'd1023, 1'b1},
    '{12'd4095, 12'd4095, 10'd1023, 10'd1023, 1'b1},
    '{12'd4095, 12'd4095, 10'd1023, 10'd1023, 1'b1},
    '{12'd4095, 12'd4095, 10'd1023, 10'd1023, 1'b1},
    '{12'd0, 12'd0, 10'd0, 10'd0, 1'b0}, '{12'd4095, 12'd0, 10'd1023, 10'd0, 1'b0},
    '{12'd0, 12'd4095, 10'd0, 10'd1023, 1'b0},
    '{12'd4095, 12'd4095, 10'd1023, 10'd1023, 1'b0},
    '{12'd2048, 12'd2048, 10'd512, 10'd512, 1'b0},
    '{12'd4094, 12'd4094, 10'd0, 10'd0, 1'b0},
    '{12'd4095, 12'd4094, 10'd1023, 10'd0, 1'b0},
    '{12'd4094, 12'd4095, 10'd0, 10'd1023, 1'b0},
    '{12'd4095, 12'd4095, 10'd1023, 10'd1023, 1'b0},
    '{12'd4094, 12'd4094, 10'd0, 10'd0, 1'b0},
    '{12'd10, 12'd10, 10'd5, 10'd900, 1'b1},
    '{12'd200, 12'd200, 10'd300, 10'd100, 1'b1},
    '{12'd1000, 12'd1000, 10'd20, 10'd700, 1'b1},
    '{12'd3000, 12'd3000, 10'd1000, 10'd1, 1'b1},
    '{12'd4000, 12'd4000, 10'd77, 10'd333, 1'b1}
  };

  function automatic logic signed [CoefW-1:0] scaled_ratio(logic signed [159:0] num,
                                                           longint den);
    logic signed [159:0] q;
    q = (num * 160'sd65536) / 160'(signed'(den));
    if (q > 160'sd2147483647) return 32'sh7fffffff;
    if (q < -160'sd2147483648) return 32'sh80000000;
    return q[CoefW-1:0];
  endfunction

  function automatic logic signed [159:0] dot3(longint p, longint q, longint r,
                                               longint s, longint t, longint u);
    return 160'(signed'(p)) * 160'(signed'(q)) + 160'(signed'(r)) * 160'(signed'(s))
         + 160'(signed'(t)) * 160'(signed'(u));
  endfunction

  task automatic clear_sums();
    pts_in_set = 0;
    s_rx = 0; s_ry = 0; s_rx2 = 0; s_ry2 = 0; s_rxry = 0;
    s_sx = 0; s_sxrx = 0; s_sxry = 0; s_sy = 0; s_syrx = 0; s_syry = 0;
  endtask

  task automatic fit_point(point_t p);
    longint rx, ry, sx, sy, n, ca, cb, cc, ce, cf, ci, det;
    fit_t   f;
    rx = p.rx; ry = p.ry; sx = p.sx; sy = p.sy;
    s_rx += rx; s_ry += ry; s_rx2 += rx * rx; s_ry2 += ry * ry; s_rxry += rx * ry;
    s_sx += sx; s_sxrx += sx * rx; s_sxry += sx * ry;
    s_sy += sy; s_syrx += sy * rx; s_syry += sy * ry;
    pts_in_set++;
    if (pts_in_set < NPts) return;
    n   = NPts;
    ca  = s_rx2 * s_ry2 - s_rxry * s_rxry;
    cb  = s_rxry * s_ry - s_rx * s_ry2;
    cc  = s_rx * s_rxry - s_ry * s_rx2;
    ce  = n * s_ry2 - s_ry * s_ry;
    cf  = s_rx * s_ry - n * s_rxry;
    ci  = n * s_rx2 - s_rx * s_rx;
    det = n * ca + s_rx * cb + s_ry * cc;
    f.status = (det == 0);
    foreach (f.co[k]) f.co[k] = '0;
    if (det != 0) begin
      f.co[CoXOff] = scaled_ratio(dot3(ca, s_sx, cb, s_sxrx, cc, s_sxry), det);
      f.co[CoXRx]  = scaled_ratio(dot3(cb, s_sx, ce, s_sxrx, cf, s_sxry), det);
      f.co[CoXRy]  = scaled_ratio(dot3(cc, s_sx, cf, s_sxrx, ci, s_sxry), det);
      f.co[CoYOff] = scaled_ratio(dot3(ca, s_sy, cb, s_syrx, cc, s_syry), det);
      f.co[CoYRx]  = scaled_ratio(dot3(cb, s_sy, ce, s_syrx, cf, s_syry), det);
      f.co[CoYRy]  = scaled_ratio(dot3(cc, s_sy, cf, s_syrx, ci, s_syry), det);
    end
    if (p.singular) begin
      f.status = 1'b1;
      foreach (f.co[k]) f.co[k] = '0;
    end
    fits_pending.push_back(f);
    clear_sums();
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_point(point_t p, bit busy);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_x_i    <= p.rx;
    raw_y_i    <= p.ry;
    screen_x_i <= p.sx;
    screen_y_i <= p.sy;
    do @(posedge clk_i); while (in_stall_o);
    fit_point(p);
  endtask

  function automatic point_t random_point(int kind, point_t base);
    point_t p;
    p.sx = $urandom_range(0, 1023);
    p.sy = $urandom_range(0, 1023);
    p.singular = 1'b0;
    case (kind)
      0: begin p.rx = $urandom_range(0, 4095); p.ry = $urandom_range(0, 4095); end
      1: begin p.rx = base.rx; p.ry = $urandom_range(0, 4095); end
      2: begin p.rx = $urandom_range(0, 4095); p.ry = p.rx; end
      3: begin
        p.rx = base.rx + $urandom_range(0, 2);
        p.ry = base.ry + $urandom_range(0, 2);
      end
      default: begin p.rx = $urandom_range(0, 15); p.ry = $urandom_range(0, 15); end
    endcase
    return p;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int     kind;
    bit     busy;
    point_t base;
    errors = 0;
    sending_done = 1'b0;
    clear_sums();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    raw_x_i = '0;
    raw_y_i = '0;
    screen_x_i = '0;
    screen_y_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_pts[k]) send_point(directed_pts[k], 1'b0);
    for (int s = 0; s < RandSets; s++) begin
      kind = $urandom_range(0, 19);
      kind = kind < 12 ? 0 : kind < 14 ? 1 : kind < 16 ? 2 : kind < 18 ? 3 : 4;
      busy = ($urandom_range(0, 3) == 0);
      base.rx = $urandom_range(0, 4093);
      base.ry = $urandom_range(0, 4093);
      for (int k = 0; k < NPts; k++) send_point(random_point(kind, base), busy);
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int   hold;
    bit   busy;
    fit_t want;
    fits_seen = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      busy = ($urandom_range(0, 4) == 0);
      hold = fits_seen == 3 ? LongHold : busy ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      fits_seen++;
      if (fits_pending.size() == 0) begin
        report("unexpected fit beat", 1, 0);
      end else begin
        want = fits_pending.pop_front();
        if (status_o !== want.status) report("status", status_o, want.status);
        if (x_offset_o !== want.co[CoXOff])
          report("x_offset", x_offset_o, want.co[CoXOff]);
        if (x_from_raw_x_o !== want.co[CoXRx])
          report("x_from_raw_x", x_from_raw_x_o, want.co[CoXRx]);
        if (x_from_raw_y_o !== want.co[CoXRy])
          report("x_from_raw_y", x_from_raw_y_o, want.co[CoXRy]);
        if (y_offset_o !== want.co[CoYOff])
          report("y_offset", y_offset_o, want.co[CoYOff]);
        if (y_from_raw_x_o !== want.co[CoYRx])
          report("y_from_raw_x", y_from_raw_x_o, want.co[CoYRx]);
        if (y_from_raw_y_o !== want.co[CoYRy])
          report("y_from_raw_y", y_from_raw_y_o, want.co[CoYRy]);
      end
    end
  end

  initial begin
    wait (sending_done);
    while (fits_pending.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && fits_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
